FILE: src/wmspt_pkg.sv
// Shared types and constants for the windowed mean / deviation peak tracker.
// Holds the sequencer state type and the register indexes and reset values.
// No dependencies.
package wmspt_pkg;

   typedef enum logic [15:0] {
      ST_IDLE       = 16'b0000_0000_0000_0001,
      ST_EVICT_CHK  = 16'b0000_0000_0000_0010,
      ST_EVICT_WAIT = 16'b0000_0000_0000_0100,
      ST_PUSH       = 16'b0000_0000_0000_1000,
      ST_MDIV       = 16'b0000_0000_0001_0000,
      ST_MEAN       = 16'b0000_0000_0010_0000,
      ST_PASS       = 16'b0000_0000_0100_0000,
      ST_VDIV       = 16'b0000_0000_1000_0000,
      ST_SQRT       = 16'b0000_0001_0000_0000,
      ST_FRONT_RD   = 16'b0000_0010_0000_0000,
      ST_FRONT_CHK  = 16'b0000_0100_0000_0000,
      ST_BACK_RD    = 16'b0000_1000_0000_0000,
      ST_BACK_CHK   = 16'b0001_0000_0000_0000,
      ST_INSERT     = 16'b0010_0000_0000_0000,
      ST_OUT_RD     = 16'b0100_0000_0000_0000,
      ST_OUT_WAIT   = 16'b1000_0000_0000_0000
   } state_type;

   localparam logic [7:0]  REG_SAMPLE_WINDOW = 8'd0;
   localparam logic [7:0]  REG_MAX_WINDOW    = 8'd1;

   localparam logic [7:0]  SAMPLE_WINDOW_RESET = 8'd120;
   localparam logic [11:0] MAX_WINDOW_RESET    = 12'd1800;

endpackage

FILE: src/wmspt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample ring and the peak deque. No dependencies.
module wmspt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/windowed_mean_std_peak_tracker_top.sv
// Top level of the windowed mean / deviation peak tracker.
// Depends on wmspt_pkg (states, register indexes) and wmspt_ram (ring and deque).
//
// Usage:
//   req_* carries one unsigned Q16.16 sample per transfer. rsp_* returns one
//   result per sample: the largest windowed mean still in range and the
//   deviation recorded with it. csr_* writes the two window registers
//   (index 0: sample window length, index 1: peak age limit); writing the
//   sample window length empties the sample window but keeps the deque.
//   The block works on one sample at a time and raises req_tready and
//   csr_ready only when idle. Each sample first evicts the oldest samples
//   until it fits the window, then passes through the shared bit-serial
//   divider for the mean, a deviation sweep over the ring (one entry a
//   cycle), the divider again for the variance and the bit-serial square
//   root, then the deque front and back checks, the insert and the output
//   read. With a single sample held, the sweep, the variance division and
//   the root are skipped. The next sample is taken in the cycle after the
//   result is loaded.
//   Results sit in an output register; the next sample is taken while one
//   waits, and the block holds its next result until rsp_tready frees it.
//   Reset empties the window and the deque, zeroes the epoch counter and
//   restores the register defaults. No memory clearing pass is needed.
module windowed_mean_std_peak_tracker_top #(
   parameter int SAMPLE_DEPTH = 128,
   parameter int PEAK_DEPTH   = 2048,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] peak_mean, [63:32] peak_std
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int XW   = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
   localparam int HW   = $clog2(SAMPLE_DEPTH);
   localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
   localparam int SUMW = XW + CW;
   localparam int ACCW = 2 * XW + CW;
   localparam int RW   = (ACCW + 1) / 2;
   localparam int RTW  = (RW > 33) ? RW : 33;
   localparam int RADW = 2 * RTW;
   localparam int STW  = $clog2(((ACCW > RTW) ? ACCW : RTW) + 1);
   localparam int PW   = $clog2(PEAK_DEPTH);
   localparam int FW   = $clog2(PEAK_DEPTH + 1);
   localparam int EW   = 96;

   wmspt_pkg::state_type state_ff, state_in;

   logic [7:0]      samp_len_ff, samp_len_in;
   logic [11:0]     age_len_ff, age_len_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [31:0]     epoch_ff, epoch_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [HW-1:0]   head_ff, head_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [CW-1:0]   div_ff, div_in;
   logic [ACCW-1:0] quo_ff, quo_in;
   logic [CW:0]     rem_ff, rem_in;
   logic [STW-1:0]  step_ff, step_in;
   logic [XW-1:0]   mean_ff, mean_in;
   logic [HW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [XW-1:0]   d_ff, d_in;
   logic [2*XW-1:0] p_ff, p_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [RADW-1:0] rad_ff, rad_in;
   logic [RTW+1:0]  srem_ff, srem_in;
   logic [RTW-1:0]  root_ff, root_in;
   logic [PW-1:0]   front_ff, front_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_data_ff, rsp_data_in;

   logic            ring_we, ring_re;
   logic [HW-1:0]   ring_waddr, ring_raddr;
   logic [XW-1:0]   ring_rdata;
   logic            pk_we, pk_re;
   logic [PW-1:0]   pk_waddr, pk_raddr;
   logic [EW-1:0]   pk_wdata, pk_rdata;

   logic [CW-1:0]   w_eff;
   logic [FW-1:0]   m_eff;
   logic [31:0]     wl, ml;

   // Divider step, shared by the mean and the variance division.
   logic [CW:0]     div_rsh;
   logic            div_ge;
   logic [CW:0]     div_rem;
   logic [ACCW-1:0] div_quo;

   // Square root step, one result bit a cycle.
   logic [RTW+1:0]  sq_rsh, sq_trial, sq_rem;
   logic            sq_ge;
   logic [RTW-1:0]  sq_root;

   logic [CW:0]     evict_idx;
   logic [FW:0]     back_idx, ins_idx;
   logic [31:0]     mean32, std32;
   logic [31:0]     fe, age;
   logic            front_drop;
   logic [SUMW-1:0] sum_new;

   wmspt_ram #(.WIDTH(XW), .DEPTH(SAMPLE_DEPTH)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (x_ff),
      .re    (ring_re),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   wmspt_ram #(.WIDTH(EW), .DEPTH(PEAK_DEPTH)) u_peak (
      .clock (clock),
      .we    (pk_we),
      .waddr (pk_waddr),
      .wdata (pk_wdata),
      .re    (pk_re),
      .raddr (pk_raddr),
      .rdata (pk_rdata)
   );

   // Register values are clamped into their legal ranges before use.
   always_comb begin
      wl = 32'(samp_len_ff);
      if (wl == 32'd0) begin
         wl = 32'd1;
      end else if (wl > 32'(SAMPLE_DEPTH)) begin
         wl = 32'(SAMPLE_DEPTH);
      end
      ml = 32'(age_len_ff);
      if (ml == 32'd0) begin
         ml = 32'd1;
      end else if (ml > 32'(PEAK_DEPTH)) begin
         ml = 32'(PEAK_DEPTH);
      end
      w_eff = wl[CW-1:0];
      m_eff = ml[FW-1:0];
   end

   always_comb begin
      div_rsh = {rem_ff[CW-1:0], quo_ff[ACCW-1]};
      div_ge  = div_rsh >= {1'b0, div_ff};
      div_rem = div_ge ? div_rsh - {1'b0, div_ff} : div_rsh;
      div_quo = {quo_ff[ACCW-2:0], div_ge};

      sq_rsh   = {srem_ff[RTW-1:0], rad_ff[RADW-1 -: 2]};
      sq_trial = {root_ff, 2'b01};
      sq_ge    = sq_rsh >= sq_trial;
      sq_rem   = sq_ge ? sq_rsh - sq_trial : sq_rsh;
      sq_root  = {root_ff[RTW-2:0], sq_ge};

      evict_idx = (CW+1)'(head_ff) + (CW+1)'(SAMPLE_DEPTH) - (CW+1)'(count_ff);
      if (evict_idx >= (CW+1)'(SAMPLE_DEPTH)) begin
         evict_idx = evict_idx - (CW+1)'(SAMPLE_DEPTH);
      end
      ins_idx = (FW+1)'(front_ff) + (FW+1)'(fill_ff);
      if (ins_idx >= (FW+1)'(PEAK_DEPTH)) begin
         ins_idx = ins_idx - (FW+1)'(PEAK_DEPTH);
      end
      back_idx = (FW+1)'(front_ff) + (FW+1)'(fill_ff) - (FW+1)'(1);
      if (back_idx >= (FW+1)'(PEAK_DEPTH)) begin
         back_idx = back_idx - (FW+1)'(PEAK_DEPTH);
      end

      mean32 = 32'(mean_ff);
      std32  = (|root_ff[RTW-1:32]) ? 32'hFFFF_FFFF : root_ff[31:0];
      sum_new = sum_ff + SUMW'(x_ff);

      fe  = pk_rdata[31:0];
      age = epoch_ff - fe;
      front_drop = (age >= 32'(m_eff)) || ((33'(fe) + 33'd1) < 33'(w_eff));
   end

   always_comb begin
      state_in     = state_ff;
      samp_len_in  = samp_len_ff;
      age_len_in   = age_len_ff;
      x_in         = x_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      ptr_in       = ptr_ff;
      issue_in     = issue_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      v3_in        = 1'b0;
      d_in         = d_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      front_in     = front_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      ring_we    = 1'b0;
      ring_re    = 1'b0;
      ring_waddr = head_ff;
      ring_raddr = ptr_ff;
      pk_we      = 1'b0;
      pk_re      = 1'b0;
      pk_waddr   = ins_idx[PW-1:0];
      pk_raddr   = front_ff;
      pk_wdata   = {std32, mean32, epoch_ff};

      req_tready = 1'b0;
      csr_ready  = 1'b0;

      unique case (state_ff)
         wmspt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
            if (csr_valid) begin
               unique case (csr_index)
                  wmspt_pkg::REG_SAMPLE_WINDOW: begin
                     samp_len_in = csr_data[7:0];
                     count_in    = '0;
                     head_in     = '0;
                     sum_in      = '0;
                  end
                  wmspt_pkg::REG_MAX_WINDOW: begin
                     age_len_in = csr_data[11:0];
                  end
                  default: begin
                  end
               endcase
            end
            if (req_tvalid) begin
               x_in     = req_tdata[XW-1:0];
               epoch_in = epoch_ff + 32'd1;
               state_in = wmspt_pkg::ST_EVICT_CHK;
            end
         end
         wmspt_pkg::ST_EVICT_CHK: begin
            if (count_ff >= w_eff && count_ff != '0) begin
               ring_re    = 1'b1;
               ring_raddr = evict_idx[HW-1:0];
               state_in   = wmspt_pkg::ST_EVICT_WAIT;
            end else begin
               state_in = wmspt_pkg::ST_PUSH;
            end
         end
         wmspt_pkg::ST_EVICT_WAIT: begin
            sum_in   = sum_ff - SUMW'(ring_rdata);
            count_in = count_ff - CW'(1);
            state_in = wmspt_pkg::ST_EVICT_CHK;
         end
         wmspt_pkg::ST_PUSH: begin
            ring_we  = 1'b1;
            head_in  = (head_ff == HW'(SAMPLE_DEPTH - 1)) ? '0 : head_ff + HW'(1);
            sum_in   = sum_new;
            count_in = count_ff + CW'(1);
            div_in   = count_ff + CW'(1);
            quo_in   = ACCW'(sum_new);
            rem_in   = '0;
            step_in  = STW'(ACCW);
            state_in = wmspt_pkg::ST_MDIV;
         end
         wmspt_pkg::ST_MDIV: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff - STW'(1);
            if (step_ff == STW'(1)) begin
               state_in = wmspt_pkg::ST_MEAN;
            end
         end
         wmspt_pkg::ST_MEAN: begin
            mean_in = quo_ff[XW-1:0];
            if (count_ff > CW'(1)) begin
               ptr_in   = (head_ff == '0) ? HW'(SAMPLE_DEPTH - 1) : head_ff - HW'(1);
               issue_in = count_ff;
               acc_in   = '0;
               state_in = wmspt_pkg::ST_PASS;
            end else begin
               root_in  = '0;
               state_in = wmspt_pkg::ST_FRONT_RD;
            end
         end
         wmspt_pkg::ST_PASS: begin
            // Read, deviation, square and accumulate overlap, one entry a cycle.
            if (issue_ff != '0) begin
               ring_re  = 1'b1;
               v1_in    = 1'b1;
               ptr_in   = (ptr_ff == '0) ? HW'(SAMPLE_DEPTH - 1) : ptr_ff - HW'(1);
               issue_in = issue_ff - CW'(1);
            end
            v2_in = v1_ff;
            v3_in = v2_ff;
            d_in  = (ring_rdata >= mean_ff) ? ring_rdata - mean_ff : mean_ff - ring_rdata;
            p_in  = (2*XW)'(d_ff) * (2*XW)'(d_ff);
            if (v3_ff) begin
               acc_in = acc_ff + ACCW'(p_ff);
            end
            if (issue_ff == '0 && !v1_ff && !v2_ff && !v3_ff) begin
               quo_in   = acc_ff;
               rem_in   = '0;
               div_in   = count_ff - CW'(1);
               step_in  = STW'(ACCW);
               state_in = wmspt_pkg::ST_VDIV;
            end
         end
         wmspt_pkg::ST_VDIV: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff - STW'(1);
            if (step_ff == STW'(1)) begin
               rad_in   = RADW'(div_quo);
               srem_in  = '0;
               root_in  = '0;
               step_in  = STW'(RTW);
               state_in = wmspt_pkg::ST_SQRT;
            end
         end
         wmspt_pkg::ST_SQRT: begin
            rad_in  = rad_ff << 2;
            srem_in = sq_rem;
            root_in = sq_root;
            step_in = step_ff - STW'(1);
            if (step_ff == STW'(1)) begin
               state_in = wmspt_pkg::ST_FRONT_RD;
            end
         end
         wmspt_pkg::ST_FRONT_RD: begin
            if (fill_ff == '0) begin
               state_in = wmspt_pkg::ST_BACK_RD;
            end else begin
               pk_re    = 1'b1;
               state_in = wmspt_pkg::ST_FRONT_CHK;
            end
         end
         wmspt_pkg::ST_FRONT_CHK: begin
            if (front_drop) begin
               front_in = (front_ff == PW'(PEAK_DEPTH - 1)) ? '0 : front_ff + PW'(1);
               fill_in  = fill_ff - FW'(1);
               state_in = wmspt_pkg::ST_FRONT_RD;
            end else begin
               state_in = wmspt_pkg::ST_BACK_RD;
            end
         end
         wmspt_pkg::ST_BACK_RD: begin
            if (fill_ff == '0) begin
               state_in = wmspt_pkg::ST_INSERT;
            end else begin
               pk_re    = 1'b1;
               pk_raddr = back_idx[PW-1:0];
               state_in = wmspt_pkg::ST_BACK_CHK;
            end
         end
         wmspt_pkg::ST_BACK_CHK: begin
            if (pk_rdata[63:32] <= mean32) begin
               fill_in  = fill_ff - FW'(1);
               state_in = wmspt_pkg::ST_BACK_RD;
            end else begin
               state_in = wmspt_pkg::ST_INSERT;
            end
         end
         wmspt_pkg::ST_INSERT: begin
            // A full deque loses its front; the write slot is the same either way.
            pk_we = 1'b1;
            if (fill_ff == FW'(PEAK_DEPTH)) begin
               front_in = (front_ff == PW'(PEAK_DEPTH - 1)) ? '0 : front_ff + PW'(1);
            end else begin
               fill_in = fill_ff + FW'(1);
            end
            state_in = wmspt_pkg::ST_OUT_RD;
         end
         wmspt_pkg::ST_OUT_RD: begin
            pk_re    = 1'b1;
            state_in = wmspt_pkg::ST_OUT_WAIT;
         end
         wmspt_pkg::ST_OUT_WAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pk_rdata[95:64], pk_rdata[63:32]};
               state_in     = wmspt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wmspt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wmspt_pkg::ST_IDLE;
         samp_len_ff  <= wmspt_pkg::SAMPLE_WINDOW_RESET;
         age_len_ff   <= wmspt_pkg::MAX_WINDOW_RESET;
         epoch_ff     <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         sum_ff       <= '0;
         front_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         step_ff      <= '0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         samp_len_ff  <= samp_len_in;
         age_len_ff   <= age_len_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         step_ff      <= step_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      mean_ff     <= mean_in;
      ptr_ff      <= ptr_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for windowed_mean_std_peak_tracker_top.
// Streams Q16.16 samples under several window settings and compares every result with a
// behavioral predictor of the mean, deviation and peak deque or with a value typed in its row.
// Depends on wmspt_pkg and the RTL of the block.
module testbench;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          HOLD_CYCLES    = 3000;
   localparam int          RING_DEPTH     = 128;
   localparam int          DEQUE_DEPTH    = 2048;
   localparam int          PENDING_DEPTH  = 16;
   localparam logic [7:0]  REG_UNUSED     = 8'd2;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   index;
      logic [31:0]  value;
      bit           typed;
      logic [31:0]  mean;
      logic [31:0]  dev;
   } stim_row_type;

   typedef struct {
      logic [31:0] mean;
      logic [31:0] dev;
   } peak_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   // Predictor state.
   logic [31:0] ring [RING_DEPTH];
   int unsigned held_count;
   logic [6:0]  ring_head;
   logic [39:0] window_sum;
   logic [31:0] epoch;
   logic [31:0] dq_epoch [DEQUE_DEPTH];
   logic [31:0] dq_mean  [DEQUE_DEPTH];
   logic [31:0] dq_dev   [DEQUE_DEPTH];
   int unsigned dq_front, dq_fill;
   logic [7:0]  win_len;
   logic [11:0] age_len;

   // Results still owed by the block, oldest at pending_rd.
   peak_type    pending [PENDING_DEPTH];
   int unsigned pending_wr, pending_rd;
   int          mismatches, samples_sent, peaks_checked, csr_writes;
   int          idle_cycles, burst_left;
   bit          calm, hold_req;
   logic [31:0] level;

   windowed_mean_std_peak_tracker_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] floor_sqrt(input logic [79:0] v);
      logic [39:0] root, trial;
      root = '0;
      for (int b = 39; b >= 0; b--) begin
         trial = root | (40'd1 << b);
         if ({40'd0, trial} * {40'd0, trial} <= v)
            root = trial;
      end
      return (root > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
   endfunction

   task automatic apply_register(input logic [7:0] index, input logic [31:0] value);
      if (index == wmspt_pkg::REG_SAMPLE_WINDOW) begin
         win_len = value[7:0];
         held_count = 0;
         ring_head = '0;
         window_sum = '0;
      end else if (index == wmspt_pkg::REG_MAX_WINDOW) begin
         age_len = value[11:0];
      end
   endtask

   task automatic track_peak(input logic [31:0] x, output peak_type peak);
      int unsigned w, m, back;
      logic [39:0] mean;
      logic [79:0] acc;
      logic [31:0] s, d, dev, fe;
      w = (win_len == 0) ? 1 : ((win_len > RING_DEPTH) ? RING_DEPTH : win_len);
      m = (age_len == 0) ? 1 : ((age_len > DEQUE_DEPTH) ? DEQUE_DEPTH : age_len);
      epoch = epoch + 1;
      while (held_count >= w && held_count > 0) begin
         window_sum -= ring[7'(ring_head - 7'(held_count))];
         held_count--;
      end
      ring[ring_head] = x;
      ring_head = ring_head + 1;
      window_sum += x;
      held_count++;
      mean = window_sum / held_count;
      dev = '0;
      if (held_count > 1) begin
         acc = '0;
         for (int i = 0; i < held_count; i++) begin
            s = ring[7'(ring_head - 7'(i) - 7'd1)];
            d = (s >= mean[31:0]) ? s - mean[31:0] : mean[31:0] - s;
            acc += {48'd0, d} * {48'd0, d};
         end
         dev = floor_sqrt(acc / (held_count - 1));
      end
      // Expired and warm-up entries leave from the front.
      while (dq_fill > 0) begin
         fe = dq_epoch[dq_front];
         if ((epoch - fe) >= m || ({1'b0, fe} + 33'd1) < w) begin
            dq_front = (dq_front + 1) % DEQUE_DEPTH;
            dq_fill--;
         end else break;
      end
      // Entries that the new mean dominates leave from the back.
      while (dq_fill > 0) begin
         back = (dq_front + dq_fill - 1) % DEQUE_DEPTH;
         if (dq_mean[back] <= mean[31:0]) dq_fill--;
         else break;
      end
      if (dq_fill >= DEQUE_DEPTH) begin
         dq_front = (dq_front + 1) % DEQUE_DEPTH;
         dq_fill--;
      end
      back = (dq_front + dq_fill) % DEQUE_DEPTH;
      dq_epoch[back] = epoch;
      dq_mean[back] = mean[31:0];
      dq_dev[back] = dev;
      dq_fill++;
      peak.mean = dq_mean[dq_front];
      peak.dev = dq_dev[dq_front];
   endtask

   task automatic send_sample(input logic [31:0] x, input bit typed,
                              input peak_type typed_peak);
      peak_type peak;
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= x;
      do @(posedge clock); while (!req_tready);
      track_peak(x, peak);
      pending[pending_wr % PENDING_DEPTH] = typed ? typed_peak : peak;
      pending_wr++;
      samples_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_wr != pending_rd) @(posedge clock);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] next_sample();
      case ($urandom_range(0, 7))
         0, 1, 2: level = $urandom;
         3: level = level - $urandom_range(0, 32'h0004_0000);
         4: level = level + $urandom_range(0, 32'h0004_0000);
         5: ;
         6: level = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: level = $urandom_range(0, 32'h0003_FFFF);
      endcase
      return level;
   endfunction

   // Result receiver: random stalls, with a long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      peak_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_wr == pending_rd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: mean %h std %h",
                        rsp_tdata[31:0], rsp_tdata[63:32]);
         end else begin
            want = pending[pending_rd % PENDING_DEPTH];
            pending_rd++;
            peaks_checked++;
            if (rsp_tdata[31:0] !== want.mean || rsp_tdata[63:32] !== want.dev) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected mean %h std %h, got mean %h std %h",
                           peaks_checked, want.mean, want.dev,
                           rsp_tdata[31:0], rsp_tdata[63:32]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("windowed_mean_std_peak_tracker_top: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      peak_type     typed_peak;
      logic [7:0]   phase_win [6];
      logic [11:0]  phase_age [6];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_req = 1'b0;
      pending_wr = 0;
      pending_rd = 0;
      mismatches = 0;
      samples_sent = 0;
      peaks_checked = 0;
      csr_writes = 0;
      idle_cycles = 0;
      burst_left = 0;
      level = '0;
      held_count = 0;
      ring_head = '0;
      window_sum = '0;
      epoch = '0;
      dq_front = 0;
      dq_fill = 0;
      win_len = wmspt_pkg::SAMPLE_WINDOW_RESET;
      age_len = wmspt_pkg::MAX_WINDOW_RESET;

      // First sample after reset is its own peak with zero deviation.
      rows = '{
         '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0},
         '{ROW_SAMPLE, '0, 32'h0000_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h8000_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0000_0001, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0001_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0000_FFFF, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'hAAAA_AAAA, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h5555_5555, 0, '0, '0},
         '{ROW_CSR, wmspt_pkg::REG_MAX_WINDOW, 32'd1, 0, '0, '0},
         '{ROW_CSR, wmspt_pkg::REG_SAMPLE_WINDOW, 32'd1, 0, '0, '0},
         // With an age limit of one, every older peak expires at once.
         '{ROW_SAMPLE, '0, 32'h1234_5678, 1, 32'h1234_5678, 32'h0},
         '{ROW_SAMPLE, '0, 32'h0000_0000, 1, 32'h0000_0000, 32'h0},
         '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0},
         '{ROW_CSR, wmspt_pkg::REG_SAMPLE_WINDOW, 32'd3, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0003_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0001_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0002_0000, 0, '0, '0},
         '{ROW_CSR, REG_UNUSED, 32'hFFFF_FFFF, 0, '0, '0},
         '{ROW_CSR, wmspt_pkg::REG_MAX_WINDOW, 32'hFFFF_F003, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0009_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0002_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0001_0000, 0, '0, '0},
         '{ROW_SAMPLE, '0, 32'h0000_8000, 0, '0, '0}
      };
      phase_win = '{8'd128, 8'd0, 8'd255, 8'd4, 8'd16, 8'd120};
      phase_age = '{12'd2048, 12'd0, 12'd4095, 12'd7, 12'd40, 12'd1800};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            write_register(rows[i].index, rows[i].value);
         end else begin
            typed_peak.mean = rows[i].mean;
            typed_peak.dev = rows[i].dev;
            send_sample(rows[i].value, rows[i].typed, typed_peak);
         end
      end

      for (int p = 0; p < 6; p++) begin
         calm = (p == 5);
         write_register(wmspt_pkg::REG_SAMPLE_WINDOW,
                        {24'($urandom_range(0, 32'hFF_FFFF)), phase_win[p]});
         write_register(wmspt_pkg::REG_MAX_WINDOW,
                        {20'($urandom_range(0, 32'hF_FFFF)), phase_age[p]});
         if (p == 2)
            write_register(8'($urandom_range(2, 255)), $urandom);
         for (int n = 0; n < 72; n++) begin
            // Stall the result side for a long stretch while samples keep being offered.
            if (p == 0 && n == 30) hold_req = 1'b1;
            send_sample(next_sample(), 0, typed_peak);
         end
      end

      drain();
      repeat (400) @(posedge clock);
      $display("Sent %0d samples and checked %0d peak results over %0d register writes,",
               samples_sent, peaks_checked, csr_writes);
      $display("covering window lengths 1..128 with saturation and peak ages 1..2048.");
      if (mismatches == 0)
         $display("windowed_mean_std_peak_tracker_top: match");
      else
         $display("windowed_mean_std_peak_tracker_top: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
src/wmspt_pkg.sv
src/wmspt_ram.sv
src/windowed_mean_std_peak_tracker_top.sv
tb/sv/testbench.sv
